// ----- src/rmq_pkg.sv -----
// ============================================================================
// rmq_pkg: shared constants and types for the range majority query block
// Sizes, action codes and the controller/datapath command and status groups.
// ============================================================================
package rmq_pkg;

   // Storage size
   localparam int MAX_LEN    = 1024;
   localparam int VALUE_BITS = 16;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int CNT_W      = $clog2(MAX_LEN + 1);

   // Fixed field widths
   localparam int ACT_W = 2;
   localparam int VAL_W = 16;
   localparam int POS_W = 11;
   localparam int MAJ_W = 16;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic clear;   // empty the sequence
      logic append;  // store incoming value, set up append result
      logic start;   // latch query range, zero vote/count state
      logic reject;  // invalid query, error result
      logic issue;   // read current address, advance
      logic pass;    // 0: vote pass, 1: count pass (qualifies issue)
      logic rewind;  // address back to range start
      logic finish;  // load output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_ok;    // incoming query range is valid
      logic at_last;   // address is at range end
      logic out_free;  // output register can take a result
   } status_type;

endpackage

// ----- src/rmq_req_if.sv -----
// ============================================================================
// rmq_req_if: request channel
// Valid/ready channel carrying one request item.
// ============================================================================
interface rmq_req_if
   import rmq_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   logic [VAL_W-1:0] value;
   logic [POS_W-1:0] left_pos;
   logic [POS_W-1:0] right_pos;

   modport source (output valid, action, value, left_pos, right_pos, input ready);
   modport sink   (input valid, action, value, left_pos, right_pos, output ready);
endinterface

// ----- src/rmq_rsp_if.sv -----
// ============================================================================
// rmq_rsp_if: response channel
// Valid/ready channel carrying one result item.
// ============================================================================
interface rmq_rsp_if
   import rmq_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [MAJ_W-1:0] majority;
   logic             found;
   logic             error;

   modport source (output valid, majority, found, error, input ready);
   modport sink   (input valid, majority, found, error, output ready);
endinterface

// ----- src/rmq_ram.sv -----
// ============================================================================
// rmq_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ============================================================================
module rmq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/rmq_datapath.sv -----
// ============================================================================
// rmq_datapath: storage, scan address, vote/count and result register
// Executes controller commands; one RAM read per issue, data in the next cycle.
// ============================================================================
module rmq_datapath
   import rmq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [VAL_W-1:0] req_value,
   input  logic [POS_W-1:0] req_left_pos,
   input  logic [POS_W-1:0] req_right_pos,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [MAJ_W-1:0] rsp_majority,
   output logic             rsp_found,
   output logic             rsp_error
);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ADDR_W-1:0]     lo_ff, lo_in;
   logic [ADDR_W-1:0]     hi_ff, hi_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  rdv_ff, rdv_in;
   logic                  rd_pass_ff, rd_pass_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [CNT_W-1:0]      votes_ff, votes_in;
   logic [CNT_W-1:0]      hits_ff, hits_in;
   logic                  res_err_ff, res_err_in;
   logic                  res_query_ff, res_query_in;
   logic                  out_valid_ff, out_valid_in;
   logic [MAJ_W-1:0]      out_maj_ff, out_maj_in;
   logic                  out_found_ff, out_found_in;
   logic                  out_err_ff, out_err_in;

   logic [VALUE_BITS-1:0] rd_data;
   logic                  full;
   logic [CNT_W-1:0]      len;
   logic                  is_major;

   rmq_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.append && !full),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (req_value[VALUE_BITS-1:0]),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign full = (cnt_ff == CNT_W'(MAX_LEN));

   // Range check on the incoming request fields
   always_comb begin
      status.req_ok = (req_left_pos != '0) && (req_left_pos <= req_right_pos) &&
                      (32'(req_right_pos) <= 32'(cnt_ff));
      status.at_last  = (addr_ff == hi_ff);
      status.out_free = !out_valid_ff || rsp_ready;
   end

   // Majority when hits > len/2
   assign len      = CNT_W'(hi_ff) - CNT_W'(lo_ff) + CNT_W'(1);
   assign is_major = {hits_ff, 1'b0} > {1'b0, len};

   always_comb begin
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      addr_in      = addr_ff;
      cand_in      = cand_ff;
      votes_in     = votes_ff;
      hits_in      = hits_ff;
      res_err_in   = res_err_ff;
      res_query_in = res_query_ff;
      rdv_in       = cmd.issue;
      rd_pass_in   = cmd.pass;

      if (cmd.clear) begin
         cnt_in = '0;
      end
      if (cmd.append) begin
         res_err_in   = full;
         res_query_in = 1'b0;
         if (!full) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.reject) begin
         res_err_in   = 1'b1;
         res_query_in = 1'b0;
      end
      if (cmd.start) begin
         lo_in        = ADDR_W'(req_left_pos - POS_W'(1));
         hi_in        = ADDR_W'(req_right_pos - POS_W'(1));
         addr_in      = ADDR_W'(req_left_pos - POS_W'(1));
         votes_in     = '0;
         hits_in      = '0;
         res_err_in   = 1'b0;
         res_query_in = 1'b1;
      end
      if (cmd.issue) begin
         addr_in = addr_ff + ADDR_W'(1);
      end
      if (cmd.rewind) begin
         addr_in = lo_ff;
      end

      // Process read data, which returns in the cycle after issue
      if (rdv_ff) begin
         if (!rd_pass_ff) begin
            if (votes_ff == '0) begin
               cand_in  = rd_data;
               votes_in = CNT_W'(1);
            end else if (rd_data == cand_ff) begin
               votes_in = votes_ff + CNT_W'(1);
            end else begin
               votes_in = votes_ff - CNT_W'(1);
            end
         end else if (rd_data == cand_ff) begin
            hits_in = hits_ff + CNT_W'(1);
         end
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_maj_in   = out_maj_ff;
      out_found_in = out_found_ff;
      out_err_in   = out_err_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_found_in = res_query_ff && is_major;
         out_maj_in   = (res_query_ff && is_major) ? MAJ_W'(cand_ff) : '0;
         out_err_in   = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rdv_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rdv_ff       <= rdv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      addr_ff      <= addr_in;
      rd_pass_ff   <= rd_pass_in;
      cand_ff      <= cand_in;
      votes_ff     <= votes_in;
      hits_ff      <= hits_in;
      res_err_ff   <= res_err_in;
      res_query_ff <= res_query_in;
      out_maj_ff   <= out_maj_in;
      out_found_ff <= out_found_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_majority = out_maj_ff;
   assign rsp_found    = out_found_ff;
   assign rsp_error    = out_err_ff;

endmodule

// ----- src/rmq_ctrl.sv -----
// ============================================================================
// rmq_ctrl: request sequencer
// Accepts requests, runs the vote and count scans, hands off results.
// ============================================================================
module rmq_ctrl
   import rmq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [ACT_W-1:0] req_action,
   input  status_type       status,
   output cmd_type          cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_VOTE   = 3'd1;
   localparam logic [2:0] ST_VDRAIN = 3'd2;
   localparam logic [2:0] ST_COUNT  = 3'd3;
   localparam logic [2:0] ST_CDRAIN = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  ACT_APPEND: begin
                     cmd.append = 1'b1;
                     state_in   = ST_DONE;
                  end
                  ACT_QUERY: begin
                     if (status.req_ok) begin
                        cmd.start = 1'b1;
                        state_in  = ST_VOTE;
                     end else begin
                        cmd.reject = 1'b1;
                        state_in   = ST_DONE;
                     end
                  end
                  default: ;  // unused code: dropped
               endcase
            end
         end
         ST_VOTE: begin
            cmd.issue = 1'b1;
            if (status.at_last) begin
               state_in = ST_VDRAIN;
            end
         end
         ST_VDRAIN: begin
            cmd.rewind = 1'b1;
            state_in   = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.issue = 1'b1;
            cmd.pass  = 1'b1;
            if (status.at_last) begin
               state_in = ST_CDRAIN;
            end
         end
         ST_CDRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/range_majority_query.sv -----
// ============================================================================
// range_majority_query: range majority element query engine
// Keeps a value sequence in RAM; answers strict-majority queries over a
// position range with a Boyer-Moore vote scan followed by a count scan.
// ============================================================================
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+-----------------------------------
//   req_ch   | in  | valid/ready         | action, value, left_pos, right_pos
//   rsp_ch   | out | valid/ready         | majority, found, error
//
// Scans: a valid query of len = right_pos - left_pos + 1 entries reads each
//   entry twice; the single RAM read port streams one entry per cycle, once
//   per scan.
// Reset: synchronous, active high; empties the sequence and the result slot.
//   RAM contents are not cleared; only entries below the count are read.
// Stalls: the result sits in an output register, so a new item is taken
//   while the previous result waits; finishing waits for that slot.
//
module range_majority_query
   import rmq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_ch,
   rmq_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   // Sequencer: owns the request handshake and the scan order
   rmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_action (req_ch.action),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: sequence store, vote/count state, result register
   rmq_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_ch.value),
      .req_left_pos  (req_ch.left_pos),
      .req_right_pos (req_ch.right_pos),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_majority  (rsp_ch.majority),
      .rsp_found     (rsp_ch.found),
      .rsp_error     (rsp_ch.error)
   );

   // A result is only loaded when the output slot is free
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result loaded over a pending item");

   // At most one setup command per accepted item
   a_setup_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.append, cmd.start, cmd.reject}))
      else $error("conflicting setup commands");

   // Starting a scan takes the block off the request channel
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_ch.ready)
      else $error("request accepted during a scan");

   // Scan reads never overlap a result load, and occur only while requests are held off
   a_issue_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !cmd.finish && !req_ch.ready)
      else $error("scan read outside a scan");

endmodule

// ----- tb/range_majority_query_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// range_majority_query_tb: self-checking testbench for range_majority_query
// Feeds clear, append, query and unused-code items, with random idles on both channels.
// A behavioral copy of the sequence predicts every result, and each response
// is checked field by field, in order, against those predictions.
// ============================================================================
module range_majority_query_tb;
   import rmq_pkg::*;

   // action 3 has no meaning; the block must drop it silently
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   localparam int RESET_CYCLES = 11;
   localparam int MAX_IDLE     = 18;
   localparam int DRAIN_CYCLES = 64;         // quiet time after the last result
   localparam int CYCLE_LIMIT  = 2_000_000;  // watchdog, far past a slow run
   localparam int RANDOM_ITEMS = 265;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] left_pos;
      logic [POS_W-1:0] right_pos;
   } req_item_type;

   typedef struct packed {
      logic [MAJ_W-1:0] majority;
      logic             found;
      logic             error;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmq_req_if req_ch ();
   rmq_rsp_if rsp_ch ();

   range_majority_query u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Rising edge at time 0, so the reset branches below drive every input
   // to a known value right away.
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // --------------------------------------------------------------------------
   // Shared state
   // --------------------------------------------------------------------------
   req_item_type     pending_items [$];     // stimulus not yet presented
   answer_type       expected_answers [$];  // predicted results, oldest first
   logic [VAL_W-1:0] seq_copy [MAX_LEN];    // predictor's copy of the sequence
   int unsigned      seq_len = 0;           // predictor's element count
   int unsigned      gen_len = 0;           // count as seen by the generator
   int unsigned      cycle_count = 0;
   int               fail_count = 0;

   // Driver side
   req_item_type     req_cur = '0;
   bit               req_busy = 1'b0;
   int               req_wait = 0;
   bit               req_calm = 1'b0;

   // Response side
   int               rsp_stall = 1;
   bit               rsp_calm = 1'b0;

   // Idle draw per item; a calm stretch means back-to-back traffic.
   function automatic int idle_draw(inout bit calm);
      if ($urandom_range(0, 19) == 0)
         calm = !calm;
      return calm ? 0 : int'($urandom_range(0, MAX_IDLE));
   endfunction

   // --------------------------------------------------------------------------
   // Predictor: applies one accepted item to the sequence copy. Returns 1 when
   // the item produces a result, with that result in ans.
   // --------------------------------------------------------------------------
   function automatic bit predict_majority(input req_item_type it, output answer_type ans);
      logic [VAL_W-1:0] cand;
      int unsigned      votes;
      int unsigned      hits;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      i;
      ans   = '0;
      cand  = '0;
      votes = 0;
      hits  = 0;
      lo    = int'(it.left_pos);
      hi    = int'(it.right_pos);
      case (it.action)
         ACT_CLEAR: begin
            seq_len = 0;
            return 1'b0;
         end
         ACT_APPEND: begin
            // full: value dropped, error flagged
            if (seq_len >= MAX_LEN) begin
               ans.error = 1'b1;
            end else begin
               seq_copy[seq_len] = it.value;
               seq_len++;
            end
            return 1'b1;
         end
         ACT_QUERY: begin
            if (lo < 1 || lo > hi || hi > seq_len) begin
               ans.error = 1'b1;
               return 1'b1;
            end
            // vote pass: leaves the only value that can hold a majority
            for (i = lo - 1; i < hi; i++) begin
               if (votes == 0) begin
                  cand  = seq_copy[i];
                  votes = 1;
               end else if (seq_copy[i] == cand) begin
                  votes++;
               end else begin
                  votes--;
               end
            end
            // count pass: confirm it
            for (i = lo - 1; i < hi; i++)
               if (seq_copy[i] == cand)
                  hits++;
            if (hits >= (hi - lo + 1) / 2 + 1) begin
               ans.majority = cand;
               ans.found    = 1'b1;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus helper. Fields the action does not use get random content, so
   // the block is seen to ignore them.
   // --------------------------------------------------------------------------
   task automatic queue_item(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                             input int unsigned lo, input int unsigned hi);
      req_item_type it;
      it.action    = act;
      it.value     = (act == ACT_APPEND) ? val : VAL_W'($urandom);
      it.left_pos  = (act == ACT_QUERY) ? POS_W'(lo) : POS_W'($urandom);
      it.right_pos = (act == ACT_QUERY) ? POS_W'(hi) : POS_W'($urandom);
      if (act == ACT_CLEAR)
         gen_len = 0;
      else if (act == ACT_APPEND && gen_len < MAX_LEN)
         gen_len++;
      pending_items.push_back(it);
   endtask

   // --------------------------------------------------------------------------
   // Reset sequencing and watchdog
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RESET_CYCLES - 1)
         reset <= 1'b0;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Request driver: one item at a time from pending_items, with a random
   // gap drawn after each accepted item.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_busy = 1'b0;
         req_wait = 0;
      end else begin
         if (req_busy && req_ch.ready) begin
            req_busy = 1'b0;
            req_wait = idle_draw(req_calm);
         end
         if (!req_busy) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (pending_items.size() > 0) begin
               req_cur  = pending_items.pop_front();
               req_busy = 1'b1;
            end
         end
      end
      // one assignment per signal per edge; valid stays high across
      // back-to-back items
      req_ch.valid     <= req_busy;
      req_ch.action    <= req_cur.action;
      req_ch.value     <= req_cur.value;
      req_ch.left_pos  <= req_cur.left_pos;
      req_ch.right_pos <= req_cur.right_pos;
   end

   // --------------------------------------------------------------------------
   // Request monitor: every accepted item goes through the predictor
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      req_item_type seen;
      answer_type   ans;
      if (!reset && req_ch.valid && req_ch.ready) begin
         seen = '{action: req_ch.action, value: req_ch.value,
                  left_pos: req_ch.left_pos, right_pos: req_ch.right_pos};
         if (predict_majority(seen, ans))
            expected_answers.push_back(ans);
      end
   end

   // --------------------------------------------------------------------------
   // Response monitor: random back-pressure, in-order field compare
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_stall = 1;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: result with none expected: majority=%h found=%b error=%b",
                     $time, rsp_ch.majority, rsp_ch.found, rsp_ch.error);
            fail_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_ch.majority !== want.majority) begin
               $display("%0t: majority mismatch: expected %h, actual %h",
                        $time, want.majority, rsp_ch.majority);
               fail_count++;
            end
            if (rsp_ch.found !== want.found) begin
               $display("%0t: found mismatch: expected %b, actual %b",
                        $time, want.found, rsp_ch.found);
               fail_count++;
            end
            if (rsp_ch.error !== want.error) begin
               $display("%0t: error mismatch: expected %b, actual %b",
                        $time, want.error, rsp_ch.error);
               fail_count++;
            end
         end
         rsp_stall = idle_draw(rsp_calm);
      end else if (rsp_stall > 0) begin
         rsp_stall--;
      end
      rsp_ch.ready <= (rsp_stall == 0);
   end

   // --------------------------------------------------------------------------
   // Stimulus and end of run
   // --------------------------------------------------------------------------
   initial begin
      int unsigned      counted;
      int unsigned      pick;
      int unsigned      lo;
      int unsigned      hi;
      logic [VAL_W-1:0] pool_major;
      logic [VAL_W-1:0] pool_minor;

      // Directed: extremes, every action, each corner case
      queue_item(ACT_QUERY, '0, 1, 1);              // query on an empty sequence
      queue_item(ACT_APPEND, 16'h0000, 0, 0);
      queue_item(ACT_APPEND, 16'hFFFF, 0, 0);
      queue_item(ACT_APPEND, 16'hFFFF, 0, 0);
      queue_item(ACT_APPEND, 16'h5555, 0, 0);
      queue_item(ACT_APPEND, 16'hFFFF, 0, 0);
      queue_item(ACT_QUERY, '0, 1, 5);              // FFFF, 3 of 5
      queue_item(ACT_QUERY, '0, 1, 4);              // 2 of 4 is not a majority
      queue_item(ACT_QUERY, '0, 2, 3);
      queue_item(ACT_QUERY, '0, 1, 1);              // majority value 0, found set
      queue_item(ACT_QUERY, '0, 5, 5);
      queue_item(ACT_QUERY, '0, 0, 3);              // left below 1
      queue_item(ACT_QUERY, '0, 4, 2);              // left past right
      queue_item(ACT_QUERY, '0, 5, 6);              // right past the count
      queue_item(ACT_QUERY, '0, 2047, 2047);        // all position bits set
      queue_item(ACT_QUERY, '0, 1, 2047);
      queue_item(ACT_UNUSED, '0, 0, 0);             // ignored
      queue_item(ACT_CLEAR, '0, 0, 0);
      queue_item(ACT_QUERY, '0, 1, 1);              // cleared: now out of range
      queue_item(ACT_APPEND, 16'hAAAA, 0, 0);
      queue_item(ACT_APPEND, 16'h5555, 0, 0);
      queue_item(ACT_QUERY, '0, 1, 2);              // tie, no majority
      queue_item(ACT_CLEAR, '0, 0, 0);

      // Random: mostly appends from a small value pool and in-range queries,
      // so majorities actually occur; sequences stay short, with some noise.
      pool_major = VAL_W'($urandom);
      pool_minor = VAL_W'($urandom);
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 3 || (gen_len > 40 && pick < 12)) begin
            queue_item(ACT_CLEAR, '0, 0, 0);
            pool_major = VAL_W'($urandom);
            pool_minor = VAL_W'($urandom);
            counted++;
         end else if (pick < 5) begin
            queue_item(ACT_UNUSED, '0, 0, 0);       // not counted
         end else if (pick < 11) begin
            queue_item(ACT_QUERY, '0, $urandom_range(0, 2047), $urandom_range(0, 2047));
            counted++;
         end else if (pick < 50 || gen_len == 0) begin
            pick = $urandom_range(0, 9);
            queue_item(ACT_APPEND, (pick < 6) ? pool_major :
                                   (pick < 8) ? pool_minor : VAL_W'($urandom), 0, 0);
            counted++;
         end else begin
            lo = $urandom_range(1, gen_len);
            hi = $urandom_range(lo, gen_len);
            queue_item(ACT_QUERY, '0, lo, hi);
            counted++;
         end
      end

      queue_item(ACT_CLEAR, '0, 0, 0);
      queue_item(ACT_QUERY, '0, 1, 1);

      // Drain: all items taken, all results seen, then a quiet window.
      // One extra edge lets the request monitor log the last accepted item.
      @(posedge clock);
      while (reset || pending_items.size() != 0 || req_busy)
         @(posedge clock);
      @(posedge clock);
      while (expected_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
src/rmq_pkg.sv
src/rmq_req_if.sv
src/rmq_rsp_if.sv
src/rmq_ram.sv
src/rmq_datapath.sv
src/rmq_ctrl.sv
src/range_majority_query.sv
tb/range_majority_query_tb.sv
